>>> design/ybo_pkg.sv
// shared types, constants and ring functions for the yuv420 box border overlay
package ybo_pkg;

   localparam int CW = 16;
   localparam int COL_W = 11;
   localparam int PIX_W = 8;
   localparam int MASK_W = 4;
   localparam int EDGE_W = 13;
   localparam int LW_W = 5;
   localparam int COLOR_W = 24;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_LEFT      = 3'd0,
      CSR_BOX_TOP       = 3'd1,
      CSR_BOX_RIGHT     = 3'd2,
      CSR_BOX_BOTTOM    = 3'd3,
      CSR_LINE_WIDTH    = 3'd4,
      CSR_OVERLAY_COLOR = 3'd5,
      CSR_FRAME_WIDTH   = 3'd6,
      CSR_FRAME_HEIGHT  = 3'd7
   } ybo_csr_type;

   typedef struct packed {
      logic signed [CW-1:0] left;
      logic signed [CW-1:0] top;
      logic signed [CW-1:0] right;
      logic signed [CW-1:0] bottom;
      logic signed [CW-1:0] frame_w;
      logic signed [CW-1:0] frame_h;
   } ybo_geom_type;

   typedef struct packed {
      logic [COL_W-1:0]  block_col;
      logic [COL_W-1:0]  block_row;
      logic [PIX_W-1:0]  luma_top_left;
      logic [PIX_W-1:0]  luma_top_right;
      logic [PIX_W-1:0]  luma_bottom_left;
      logic [PIX_W-1:0]  luma_bottom_right;
      logic [PIX_W-1:0]  chroma_u;
      logic [PIX_W-1:0]  chroma_v;
      logic [MASK_W-1:0] mask;
   } ybo_word_type;

   function automatic logic signed [CW-1:0] clamp_edge(input logic signed [CW-1:0] v,
                                                       input logic signed [CW-1:0] size);
      logic signed [CW-1:0] lim;
      logic signed [CW-1:0] res;
      lim = size - CW'(1);
      res = v;
      if (res > lim) begin
         res = lim;
      end
      if (res < $signed(CW'(0))) begin
         res = '0;
      end
      return res;
   endfunction

   function automatic logic ring_hit(input logic signed [CW-1:0] x,
                                     input logic signed [CW-1:0] y,
                                     input logic signed [CW-1:0] l,
                                     input logic signed [CW-1:0] r,
                                     input logic signed [CW-1:0] t,
                                     input logic signed [CW-1:0] b);
      logic side;
      logic horiz;
      logic corner;
      side   = ((x == l) || (x == r)) && (y >= t) && (y < b);
      horiz  = ((y == t) || (y == b)) && (x >= l) && (x < r);
      corner = (x == r) && (y == b);
      return side || horiz || corner;
   endfunction

endpackage

>>> design/ybo_cell.sv
// one ring cell: tests the block against one border ring and passes the word on
module ybo_cell
   import ybo_pkg::*;
#(
   parameter int RING_INDEX = 0,
   parameter int RING_W = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  ybo_geom_type       geom,
   input  logic [RING_W-1:0]  rings,
   input  logic               up_valid,
   output logic               up_ready,
   input  ybo_word_type       up_word,
   output logic               down_valid,
   input  logic               down_ready,
   output ybo_word_type       down_word
);

   logic                 valid_ff, valid_in;
   ybo_word_type         word_ff, word_in;
   logic signed [CW-1:0] k, l, r, t, b, x0, x1, y0, y1;
   logic                 active;
   logic [MASK_W-1:0]    hit;

   assign k  = $signed(CW'(RING_INDEX));
   assign l  = clamp_edge(geom.left + k, geom.frame_w);
   assign r  = clamp_edge(geom.right - k, geom.frame_w);
   assign t  = clamp_edge(geom.top + k, geom.frame_h);
   assign b  = clamp_edge(geom.bottom - k, geom.frame_h);
   assign x0 = $signed({{(CW-COL_W-1){1'b0}}, up_word.block_col, 1'b0});
   assign y0 = $signed({{(CW-COL_W-1){1'b0}}, up_word.block_row, 1'b0});
   assign x1 = x0 + CW'(1);
   assign y1 = y0 + CW'(1);
   assign active = RING_W'(RING_INDEX) < rings;

   assign hit[0] = active && ring_hit(x0, y0, l, r, t, b);
   assign hit[1] = active && ring_hit(x1, y0, l, r, t, b);
   assign hit[2] = active && ring_hit(x0, y1, l, r, t, b);
   assign hit[3] = active && ring_hit(x1, y1, l, r, t, b);

   assign up_ready = !valid_ff || down_ready;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (up_ready) begin
         valid_in     = up_valid;
         word_in      = up_word;
         word_in.mask = up_word.mask | hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign down_valid = valid_ff;
   assign down_word  = word_ff;

endmodule

>>> design/ybo_out.sv
// output stage: paints luma and chroma from the mask and holds the result word
module ybo_out
   import ybo_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [COLOR_W-1:0] color,
   input  logic               up_valid,
   output logic               up_ready,
   input  ybo_word_type       up_word,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PIX_W-1:0]   rsp_out_top_left,
   output logic [PIX_W-1:0]   rsp_out_top_right,
   output logic [PIX_W-1:0]   rsp_out_bottom_left,
   output logic [PIX_W-1:0]   rsp_out_bottom_right,
   output logic [PIX_W-1:0]   rsp_chroma_u_out,
   output logic [PIX_W-1:0]   rsp_chroma_v_out,
   output logic [MASK_W-1:0]  rsp_painted_mask
);

   logic              valid_ff, valid_in;
   ybo_word_type      word_ff, word_in;
   logic [PIX_W-1:0]  cy, cu, cv;
   logic              any_hit;

   assign cy = color[23:16];
   assign cu = color[15:8];
   assign cv = color[7:0];

   assign up_ready = !valid_ff || !rsp_stall;
   assign any_hit  = |up_word.mask;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (up_ready) begin
         valid_in = up_valid;
         word_in  = up_word;
         word_in.luma_top_left     = up_word.mask[0] ? cy : up_word.luma_top_left;
         word_in.luma_top_right    = up_word.mask[1] ? cy : up_word.luma_top_right;
         word_in.luma_bottom_left  = up_word.mask[2] ? cy : up_word.luma_bottom_left;
         word_in.luma_bottom_right = up_word.mask[3] ? cy : up_word.luma_bottom_right;
         word_in.chroma_u          = any_hit ? cu : up_word.chroma_u;
         word_in.chroma_v          = any_hit ? cv : up_word.chroma_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_out_top_left     = word_ff.luma_top_left;
   assign rsp_out_top_right    = word_ff.luma_top_right;
   assign rsp_out_bottom_left  = word_ff.luma_bottom_left;
   assign rsp_out_bottom_right = word_ff.luma_bottom_right;
   assign rsp_chroma_u_out     = word_ff.chroma_u;
   assign rsp_chroma_v_out     = word_ff.chroma_v;
   assign rsp_painted_mask     = word_ff.mask;

endmodule

>>> design/yuv420_box_border_overlay.sv
// top level: config registers, chain of ring cells and output stage
//
//   port group   dir   handshake              word
//   req_*        in    req_valid / req_stall   block position, 4 luma, u, v
//   rsp_*        out   rsp_valid / rsp_stall   4 luma, u, v, painted mask
//   csr_*        in    csr_write_enable        register index and data
//
// one word per clock while rsp_stall is low; each word passes through every ring cell
// and then the output register
// reset is synchronous and empties every stage; registers take their defaults
// a stall holds the output register; cells upstream keep filling bubbles
// and req_stall rises only once the chain is full
module yuv420_box_border_overlay
   import ybo_pkg::*;
#(
   parameter int MAX_LINE_WIDTH = 16,
   parameter int MAX_FRAME_DIM = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [COL_W-1:0]     req_block_col,
   input  logic [COL_W-1:0]     req_block_row,
   input  logic [PIX_W-1:0]     req_luma_top_left,
   input  logic [PIX_W-1:0]     req_luma_top_right,
   input  logic [PIX_W-1:0]     req_luma_bottom_left,
   input  logic [PIX_W-1:0]     req_luma_bottom_right,
   input  logic [PIX_W-1:0]     req_chroma_u_in,
   input  logic [PIX_W-1:0]     req_chroma_v_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIX_W-1:0]     rsp_out_top_left,
   output logic [PIX_W-1:0]     rsp_out_top_right,
   output logic [PIX_W-1:0]     rsp_out_bottom_left,
   output logic [PIX_W-1:0]     rsp_out_bottom_right,
   output logic [PIX_W-1:0]     rsp_chroma_u_out,
   output logic [PIX_W-1:0]     rsp_chroma_v_out,
   output logic [MASK_W-1:0]    rsp_painted_mask,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COLOR_W-1:0]   csr_write_data
);

   localparam int RING_W = $clog2(MAX_LINE_WIDTH + 1);
   localparam int NCELL = MAX_LINE_WIDTH;

   logic [EDGE_W-1:0]  box_left_ff, box_top_ff, box_right_ff, box_bottom_ff;
   logic [LW_W-1:0]    line_width_ff;
   logic [COLOR_W-1:0] overlay_color_ff;
   logic [EDGE_W-1:0]  frame_width_ff, frame_height_ff;

   ybo_geom_type       geom;
   logic [RING_W-1:0]  rings;
   logic [NCELL:0]     chain_valid;
   logic [NCELL:0]     chain_ready;
   ybo_word_type       chain_word [NCELL+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         box_left_ff      <= '0;
         box_top_ff       <= '0;
         box_right_ff     <= '0;
         box_bottom_ff    <= '0;
         line_width_ff    <= '0;
         overlay_color_ff <= '0;
         frame_width_ff   <= EDGE_W'(1920);
         frame_height_ff  <= EDGE_W'(1080);
      end else if (csr_write_enable) begin
         case (ybo_csr_type'(csr_index))
            CSR_BOX_LEFT:      box_left_ff      <= csr_write_data[EDGE_W-1:0];
            CSR_BOX_TOP:       box_top_ff       <= csr_write_data[EDGE_W-1:0];
            CSR_BOX_RIGHT:     box_right_ff     <= csr_write_data[EDGE_W-1:0];
            CSR_BOX_BOTTOM:    box_bottom_ff    <= csr_write_data[EDGE_W-1:0];
            CSR_LINE_WIDTH:    line_width_ff    <= csr_write_data[LW_W-1:0];
            CSR_OVERLAY_COLOR: overlay_color_ff <= csr_write_data;
            CSR_FRAME_WIDTH:   frame_width_ff   <= csr_write_data[EDGE_W-1:0];
            CSR_FRAME_HEIGHT:  frame_height_ff  <= csr_write_data[EDGE_W-1:0];
            default: ;
         endcase
      end
   end

   // sign-extended box edges, saturated frame size and clamped ring count
   always_comb begin
      geom.left    = $signed({{(CW-EDGE_W){box_left_ff[EDGE_W-1]}}, box_left_ff});
      geom.top     = $signed({{(CW-EDGE_W){box_top_ff[EDGE_W-1]}}, box_top_ff});
      geom.right   = $signed({{(CW-EDGE_W){box_right_ff[EDGE_W-1]}}, box_right_ff});
      geom.bottom  = $signed({{(CW-EDGE_W){box_bottom_ff[EDGE_W-1]}}, box_bottom_ff});
      geom.frame_w = (CW'(frame_width_ff) > CW'(MAX_FRAME_DIM)) ?
                     $signed(CW'(MAX_FRAME_DIM)) : $signed(CW'(frame_width_ff));
      geom.frame_h = (CW'(frame_height_ff) > CW'(MAX_FRAME_DIM)) ?
                     $signed(CW'(MAX_FRAME_DIM)) : $signed(CW'(frame_height_ff));
      rings        = (int'(line_width_ff) > MAX_LINE_WIDTH) ?
                     RING_W'(MAX_LINE_WIDTH) : RING_W'(line_width_ff);
   end

   assign chain_word[0] = {req_block_col, req_block_row,
                           req_luma_top_left, req_luma_top_right,
                           req_luma_bottom_left, req_luma_bottom_right,
                           req_chroma_u_in, req_chroma_v_in, MASK_W'(0)};

   assign chain_valid[0] = req_valid;
   assign req_stall      = !chain_ready[0];

   for (genvar i = 0; i < NCELL; i++) begin : g_ring
      ybo_cell #(
         .RING_INDEX (i),
         .RING_W     (RING_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .geom       (geom),
         .rings      (rings),
         .up_valid   (chain_valid[i]),
         .up_ready   (chain_ready[i]),
         .up_word    (chain_word[i]),
         .down_valid (chain_valid[i+1]),
         .down_ready (chain_ready[i+1]),
         .down_word  (chain_word[i+1])
      );
   end

   ybo_out u_out (
      .clock                (clock),
      .reset                (reset),
      .color                (overlay_color_ff),
      .up_valid             (chain_valid[NCELL]),
      .up_ready             (chain_ready[NCELL]),
      .up_word              (chain_word[NCELL]),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_top_left     (rsp_out_top_left),
      .rsp_out_top_right    (rsp_out_top_right),
      .rsp_out_bottom_left  (rsp_out_bottom_left),
      .rsp_out_bottom_right (rsp_out_bottom_right),
      .rsp_chroma_u_out     (rsp_chroma_u_out),
      .rsp_chroma_v_out     (rsp_chroma_v_out),
      .rsp_painted_mask     (rsp_painted_mask)
   );

   // no rings configured means nothing painted
   a_no_rings_no_paint: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && line_width_ff == '0) |-> rsp_painted_mask == '0)
      else $error("paint with zero line width");

   // painted chroma carries the overlay color
   a_chroma_painted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_painted_mask != '0) |->
         (rsp_chroma_u_out == overlay_color_ff[15:8] &&
          rsp_chroma_v_out == overlay_color_ff[7:0]))
      else $error("painted block chroma differs from color");

   // painted bottom-right luma carries the overlay Y
   a_luma_painted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_painted_mask[3]) |-> rsp_out_bottom_right == overlay_color_ff[23:16])
      else $error("painted luma differs from color");

   // a new output word comes only from a valid last cell
   a_out_from_chain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(chain_valid[NCELL]))
      else $error("output word without a source");

endmodule
